[sv/svpwm_compare_generator_macros.svh]
// Assertion macros shared by the SVPWM compare generator RTL
`ifndef SVPWM_COMPARE_GENERATOR_MACROS_SVH
`define SVPWM_COMPARE_GENERATOR_MACROS_SVH

// Condition holds at every clock edge out of reset
`define SVPWM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define SVPWM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define SVPWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/svpwm_pkg.sv]
// Constants and types for the SVPWM compare generator
package svpwm_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int IN_W       = 16;
    localparam int CMP_W      = 16;
    localparam int CODE_W     = 3;
    localparam int NUM_STAGES = 7;

    // round(sqrt3 * 2^24), kept signed
    localparam int SQ3_W = 26;
    localparam logic signed [SQ3_W-1:0] SQRT3_Q24 = 26'sd29058991;

    localparam int IBV_W   = 16;
    localparam int SAL_W   = SQ3_W + IN_W;       // sqrt3 * alpha / beta
    localparam int PJ_W    = SAL_W + 1;          // projections, sign only
    localparam int SP_W    = 44;                 // sqrt3 * 2 * projection, Q32
    localparam int TPROD_W = SP_W + IBV_W + 1;   // active time product
    localparam int NV_W    = IN_W + IBV_W + 1;   // normalized voltage
    localparam int SNB_W   = SQ3_W + NV_W;
    localparam int U_W     = 60;                 // phase voltages, Q48
    localparam int DUTY_W  = FRAC_BITS + 15;
    localparam int CLAMP_W = FRAC_BITS + 1;
    localparam int CPROD_W = CLAMP_W + CMP_W;

    localparam int SHIFT_T = 49 - FRAC_BITS;
    localparam int SHIFT_U = 50 - FRAC_BITS;

    localparam logic signed [DUTY_W-1:0] ONE_Q =
        {{(DUTY_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [DUTY_W-1:0] HALF_Q = ONE_Q >>> 1;
    localparam logic [CLAMP_W-1:0] ONE_CL = {1'b1, {FRAC_BITS{1'b0}}};

    localparam int S_TDATA_W = 2 * IN_W;
    localparam int M_TDATA_W = 56;
    localparam int M_PAD_W   = M_TDATA_W - 3 * CMP_W - CODE_W;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_MODE      = 2'd0,
        REG_BUS_RECIP = 2'd1,
        REG_PERIOD    = 2'd2
    } cfg_reg_t;

    // sextant codes, bits {c, b, a} of positive projections
    localparam logic [CODE_W-1:0] SX_NONE = 3'b000;
    localparam logic [CODE_W-1:0] SX_A    = 3'b001;
    localparam logic [CODE_W-1:0] SX_B    = 3'b010;
    localparam logic [CODE_W-1:0] SX_AB   = 3'b011;
    localparam logic [CODE_W-1:0] SX_C    = 3'b100;
    localparam logic [CODE_W-1:0] SX_AC   = 3'b101;
    localparam logic [CODE_W-1:0] SX_BC   = 3'b110;
    localparam logic [CODE_W-1:0] SX_ALL  = 3'b111;

    localparam logic MODE_MIDPOINT = 1'b0;
    localparam logic MODE_SECTOR   = 1'b1;

endpackage

[sv/svpwm_compare_generator.sv]
// SVPWM compare generator: alpha-beta voltage to three compare counts
//
//  channel | ports             | transfer content
//  --------+-------------------+-------------------------------------------
//  input   | s_tvalid/s_tready | s_tdata: volt_alpha, volt_beta
//  output  | m_tvalid/m_tready | m_tdata: compare a, b, c, sextant_code
//  config  | psel/penable/...  | mode @0x0, inverse bus voltage @0x4,
//          |                   | pwm period @0x8
//
// One transfer per cycle sustained while m_tready is high, through the seven
// register stages (products, projections, selection, time multiply,
// zero time, duty select, clamp and period multiply).
// aresetn is synchronous; it empties the pipeline and loads register defaults.
// Valid bits travel with each stage; empty stages fill while m_tready is low,
// so s_tready drops only when every stage holds a transfer.
`include "svpwm_compare_generator_macros.svh"

module svpwm_compare_generator (
    input  logic                                aclk,
    input  logic                                aresetn,
    // [15:0] volt_alpha, [31:16] volt_beta
    input  logic [svpwm_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] compare_phase_a, [31:16] compare_phase_b,
    // [47:32] compare_phase_c, [50:48] sextant_code, [55:51] zero
    output logic [svpwm_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [svpwm_pkg::PADDR_W-1:0]       paddr,
    input  logic [svpwm_pkg::PDATA_W-1:0]       pwdata,
    output logic [svpwm_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready
);

    // ---------------- configuration ----------------
    logic                               mode_reg;
    logic [svpwm_pkg::IBV_W-1:0]        ibv_reg;
    logic [svpwm_pkg::CMP_W-1:0]        period_reg;
    logic                               cfg_wr;
    svpwm_pkg::cfg_reg_t                cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = svpwm_pkg::cfg_reg_t'(paddr[svpwm_pkg::PADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= svpwm_pkg::MODE_SECTOR;
            ibv_reg    <= 16'd5461;
            period_reg <= 16'd4250;
        end else if (cfg_wr) begin
            case (cfg_idx)
                svpwm_pkg::REG_MODE:      mode_reg   <= pwdata[0];
                svpwm_pkg::REG_BUS_RECIP: ibv_reg    <= pwdata[svpwm_pkg::IBV_W-1:0];
                svpwm_pkg::REG_PERIOD:    period_reg <= pwdata[svpwm_pkg::CMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            svpwm_pkg::REG_MODE:      prdata = svpwm_pkg::PDATA_W'(mode_reg);
            svpwm_pkg::REG_BUS_RECIP: prdata = svpwm_pkg::PDATA_W'(ibv_reg);
            svpwm_pkg::REG_PERIOD:    prdata = svpwm_pkg::PDATA_W'(period_reg);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic [svpwm_pkg::NUM_STAGES-1:0] vld_reg;
    logic [svpwm_pkg::NUM_STAGES-1:0] vld_next;
    logic [svpwm_pkg::NUM_STAGES-1:0] vld_in;
    logic [svpwm_pkg::NUM_STAGES-1:0] stage_en;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        stage_en[svpwm_pkg::NUM_STAGES-1] = !vld_reg[svpwm_pkg::NUM_STAGES-1] || m_tready;
        for (int k = svpwm_pkg::NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        end
    end

    assign vld_in   = {vld_reg[svpwm_pkg::NUM_STAGES-2:0], s_tvalid};
    assign vld_next = (stage_en & vld_in) | (~stage_en & vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = vld_reg[svpwm_pkg::NUM_STAGES-1];

    logic signed [svpwm_pkg::IBV_W:0] ibv_s;
    assign ibv_s = $signed({1'b0, ibv_reg});

    // ---------------- stage 1: input products ----------------
    logic signed [svpwm_pkg::IN_W-1:0]  s_al;
    logic signed [svpwm_pkg::IN_W-1:0]  s_be;
    logic signed [svpwm_pkg::SAL_W-1:0] sal_next;
    logic signed [svpwm_pkg::SAL_W-1:0] sbe_next;
    logic signed [svpwm_pkg::NV_W-1:0]  na_next;
    logic signed [svpwm_pkg::NV_W-1:0]  nb_next;

    logic signed [svpwm_pkg::IN_W-1:0]  al_s1_reg;
    logic signed [svpwm_pkg::IN_W-1:0]  be_s1_reg;
    logic signed [svpwm_pkg::SAL_W-1:0] sal_s1_reg;
    logic signed [svpwm_pkg::SAL_W-1:0] sbe_s1_reg;
    logic signed [svpwm_pkg::NV_W-1:0]  na_s1_reg;
    logic signed [svpwm_pkg::NV_W-1:0]  nb_s1_reg;
    logic                               mode_s1_reg;

    assign s_al     = $signed(s_tdata[svpwm_pkg::IN_W-1:0]);
    assign s_be     = $signed(s_tdata[2*svpwm_pkg::IN_W-1:svpwm_pkg::IN_W]);
    assign sal_next = svpwm_pkg::SQRT3_Q24 * s_al;
    assign sbe_next = svpwm_pkg::SQRT3_Q24 * s_be;
    assign na_next  = s_al * ibv_s;
    assign nb_next  = s_be * ibv_s;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            al_s1_reg   <= s_al;
            be_s1_reg   <= s_be;
            sal_s1_reg  <= sal_next;
            sbe_s1_reg  <= sbe_next;
            na_s1_reg   <= na_next;
            nb_s1_reg   <= nb_next;
            mode_s1_reg <= mode_reg;
        end
    end

    // ---------------- stage 2: projections, sextant ----------------
    logic signed [svpwm_pkg::PJ_W-1:0]   be_sh_w;
    logic signed [svpwm_pkg::PJ_W-1:0]   pb_w;
    logic signed [svpwm_pkg::PJ_W-1:0]   pc_w;
    logic signed [svpwm_pkg::SP_W-1:0]   al3_w;
    logic [svpwm_pkg::CODE_W-1:0]        code_next;
    logic signed [svpwm_pkg::SP_W-1:0]   sa_next;
    logic signed [svpwm_pkg::SP_W-1:0]   sb_next;
    logic signed [svpwm_pkg::SP_W-1:0]   sc_next;
    logic signed [svpwm_pkg::SNB_W-1:0]  snb_next;

    logic [svpwm_pkg::CODE_W-1:0]        code_s2_reg;
    logic signed [svpwm_pkg::SP_W-1:0]   sa_s2_reg;
    logic signed [svpwm_pkg::SP_W-1:0]   sb_s2_reg;
    logic signed [svpwm_pkg::SP_W-1:0]   sc_s2_reg;
    logic signed [svpwm_pkg::SNB_W-1:0]  snb_s2_reg;
    logic signed [svpwm_pkg::NV_W-1:0]   na_s2_reg;
    logic                                mode_s2_reg;

    assign be_sh_w   = svpwm_pkg::PJ_W'(be_s1_reg) <<< 24;
    assign pb_w      = svpwm_pkg::PJ_W'(sal_s1_reg) - be_sh_w;
    assign pc_w      = -svpwm_pkg::PJ_W'(sal_s1_reg) - be_sh_w;
    // alpha projection is beta scaled, so its sign is beta's
    assign code_next = {(pc_w > 0), (pb_w > 0), (be_s1_reg > 0)};
    assign al3_w     = (svpwm_pkg::SP_W'(al_s1_reg) <<< 1) + svpwm_pkg::SP_W'(al_s1_reg);
    assign sa_next   = svpwm_pkg::SP_W'(sbe_s1_reg) <<< 1;
    assign sb_next   = (al3_w <<< 24) - svpwm_pkg::SP_W'(sbe_s1_reg);
    assign sc_next   = -(al3_w <<< 24) - svpwm_pkg::SP_W'(sbe_s1_reg);
    assign snb_next  = svpwm_pkg::SQRT3_Q24 * nb_s1_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            code_s2_reg <= code_next;
            sa_s2_reg   <= sa_next;
            sb_s2_reg   <= sb_next;
            sc_s2_reg   <= sc_next;
            snb_s2_reg  <= snb_next;
            na_s2_reg   <= na_s1_reg;
            mode_s2_reg <= mode_s1_reg;
        end
    end

    // ---------------- stage 3: operand select, phase voltages ----------------
    logic signed [svpwm_pkg::SP_W-1:0] sp1_next;
    logic signed [svpwm_pkg::SP_W-1:0] sp2_next;
    logic signed [svpwm_pkg::U_W-1:0]  na_sh_w;
    logic signed [svpwm_pkg::U_W-1:0]  ua_next;
    logic signed [svpwm_pkg::U_W-1:0]  ub_next;
    logic signed [svpwm_pkg::U_W-1:0]  uc_next;

    logic signed [svpwm_pkg::SP_W-1:0] sp1_s3_reg;
    logic signed [svpwm_pkg::SP_W-1:0] sp2_s3_reg;
    logic [svpwm_pkg::CODE_W-1:0]      code_s3_reg;
    logic signed [svpwm_pkg::U_W-1:0]  ua_s3_reg;
    logic signed [svpwm_pkg::U_W-1:0]  ub_s3_reg;
    logic signed [svpwm_pkg::U_W-1:0]  uc_s3_reg;
    logic                              mode_s3_reg;

    always_comb begin
        case (code_s2_reg)
            svpwm_pkg::SX_AB: begin
                sp1_next = sb_s2_reg;
                sp2_next = sa_s2_reg;
            end
            svpwm_pkg::SX_A: begin
                sp1_next = -sc_s2_reg;
                sp2_next = -sb_s2_reg;
            end
            svpwm_pkg::SX_AC: begin
                sp1_next = sa_s2_reg;
                sp2_next = sc_s2_reg;
            end
            svpwm_pkg::SX_C: begin
                sp1_next = -sa_s2_reg;
                sp2_next = -sb_s2_reg;
            end
            svpwm_pkg::SX_BC: begin
                sp1_next = sc_s2_reg;
                sp2_next = sb_s2_reg;
            end
            svpwm_pkg::SX_B: begin
                sp1_next = -sc_s2_reg;
                sp2_next = -sa_s2_reg;
            end
            default: begin
                sp1_next = '0;
                sp2_next = '0;
            end
        endcase
    end

    assign na_sh_w = svpwm_pkg::U_W'(na_s2_reg) <<< 24;
    assign ua_next = svpwm_pkg::U_W'(na_s2_reg) <<< 25;
    assign ub_next = svpwm_pkg::U_W'(snb_s2_reg) - na_sh_w;
    assign uc_next = -svpwm_pkg::U_W'(snb_s2_reg) - na_sh_w;

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            sp1_s3_reg  <= sp1_next;
            sp2_s3_reg  <= sp2_next;
            code_s3_reg <= code_s2_reg;
            ua_s3_reg   <= ua_next;
            ub_s3_reg   <= ub_next;
            uc_s3_reg   <= uc_next;
            mode_s3_reg <= mode_s2_reg;
        end
    end

    // ---------------- stage 4: active times, min/max ----------------
    logic signed [svpwm_pkg::TPROD_W-1:0] tp1_w;
    logic signed [svpwm_pkg::TPROD_W-1:0] tp2_w;
    logic signed [svpwm_pkg::TPROD_W-1:0] tsh1_w;
    logic signed [svpwm_pkg::TPROD_W-1:0] tsh2_w;
    logic signed [svpwm_pkg::DUTY_W-1:0]  t1_next;
    logic signed [svpwm_pkg::DUTY_W-1:0]  t2_next;
    logic signed [svpwm_pkg::U_W-1:0]     umax_next;
    logic signed [svpwm_pkg::U_W-1:0]     umin_next;

    logic signed [svpwm_pkg::DUTY_W-1:0]  t1_s4_reg;
    logic signed [svpwm_pkg::DUTY_W-1:0]  t2_s4_reg;
    logic [svpwm_pkg::CODE_W-1:0]         code_s4_reg;
    logic signed [svpwm_pkg::U_W-1:0]     ua_s4_reg;
    logic signed [svpwm_pkg::U_W-1:0]     ub_s4_reg;
    logic signed [svpwm_pkg::U_W-1:0]     uc_s4_reg;
    logic signed [svpwm_pkg::U_W-1:0]     umax_s4_reg;
    logic signed [svpwm_pkg::U_W-1:0]     umin_s4_reg;
    logic                                 mode_s4_reg;

    assign tp1_w   = sp1_s3_reg * ibv_s;
    assign tp2_w   = sp2_s3_reg * ibv_s;
    // arithmetic shift floors toward minus infinity
    assign tsh1_w  = tp1_w >>> svpwm_pkg::SHIFT_T;
    assign tsh2_w  = tp2_w >>> svpwm_pkg::SHIFT_T;
    assign t1_next = $signed(tsh1_w[svpwm_pkg::DUTY_W-1:0]);
    assign t2_next = $signed(tsh2_w[svpwm_pkg::DUTY_W-1:0]);

    always_comb begin
        umax_next = ua_s3_reg;
        umin_next = ua_s3_reg;
        if (ub_s3_reg > umax_next) umax_next = ub_s3_reg;
        if (uc_s3_reg > umax_next) umax_next = uc_s3_reg;
        if (ub_s3_reg < umin_next) umin_next = ub_s3_reg;
        if (uc_s3_reg < umin_next) umin_next = uc_s3_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            t1_s4_reg   <= t1_next;
            t2_s4_reg   <= t2_next;
            code_s4_reg <= code_s3_reg;
            ua_s4_reg   <= ua_s3_reg;
            ub_s4_reg   <= ub_s3_reg;
            uc_s4_reg   <= uc_s3_reg;
            umax_s4_reg <= umax_next;
            umin_s4_reg <= umin_next;
            mode_s4_reg <= mode_s3_reg;
        end
    end

    // ---------------- stage 5: zero time, midpoint offsets ----------------
    logic signed [svpwm_pkg::DUTY_W-1:0] t0_next;
    logic signed [svpwm_pkg::U_W-1:0]    ea_next;
    logic signed [svpwm_pkg::U_W-1:0]    eb_next;
    logic signed [svpwm_pkg::U_W-1:0]    ec_next;

    logic signed [svpwm_pkg::DUTY_W-1:0] t0_s5_reg;
    logic signed [svpwm_pkg::DUTY_W-1:0] t1_s5_reg;
    logic signed [svpwm_pkg::DUTY_W-1:0] t2_s5_reg;
    logic [svpwm_pkg::CODE_W-1:0]        code_s5_reg;
    logic signed [svpwm_pkg::U_W-1:0]    ea_s5_reg;
    logic signed [svpwm_pkg::U_W-1:0]    eb_s5_reg;
    logic signed [svpwm_pkg::U_W-1:0]    ec_s5_reg;
    logic                                mode_s5_reg;

    assign t0_next = (svpwm_pkg::ONE_Q - t1_s4_reg - t2_s4_reg) >>> 1;
    assign ea_next = umax_s4_reg + umin_s4_reg - (ua_s4_reg <<< 1);
    assign eb_next = umax_s4_reg + umin_s4_reg - (ub_s4_reg <<< 1);
    assign ec_next = umax_s4_reg + umin_s4_reg - (uc_s4_reg <<< 1);

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            t0_s5_reg   <= t0_next;
            t1_s5_reg   <= t1_s4_reg;
            t2_s5_reg   <= t2_s4_reg;
            code_s5_reg <= code_s4_reg;
            ea_s5_reg   <= ea_next;
            eb_s5_reg   <= eb_next;
            ec_s5_reg   <= ec_next;
            mode_s5_reg <= mode_s4_reg;
        end
    end

    // ---------------- stage 6: duty select ----------------
    logic signed [svpwm_pkg::DUTY_W-1:0] ha_w;
    logic signed [svpwm_pkg::DUTY_W-1:0] hb_w;
    logic signed [svpwm_pkg::DUTY_W-1:0] hc_w;
    logic signed [svpwm_pkg::U_W-1:0]    esh_a_w;
    logic signed [svpwm_pkg::U_W-1:0]    esh_b_w;
    logic signed [svpwm_pkg::U_W-1:0]    esh_c_w;
    logic signed [svpwm_pkg::DUTY_W-1:0] duty_a_next;
    logic signed [svpwm_pkg::DUTY_W-1:0] duty_b_next;
    logic signed [svpwm_pkg::DUTY_W-1:0] duty_c_next;
    logic [svpwm_pkg::CODE_W-1:0]        code_out_next;

    logic signed [svpwm_pkg::DUTY_W-1:0] duty_a_s6_reg;
    logic signed [svpwm_pkg::DUTY_W-1:0] duty_b_s6_reg;
    logic signed [svpwm_pkg::DUTY_W-1:0] duty_c_s6_reg;
    logic [svpwm_pkg::CODE_W-1:0]        code_s6_reg;
    logic                                mode_s6_reg;

    // high time per phase for each sextant; codes 000 and 111 keep all phases low
    always_comb begin
        case (code_s5_reg)
            svpwm_pkg::SX_AB: begin
                ha_w = t1_s5_reg + t2_s5_reg + t0_s5_reg;
                hb_w = t2_s5_reg + t0_s5_reg;
                hc_w = t0_s5_reg;
            end
            svpwm_pkg::SX_A: begin
                ha_w = t1_s5_reg + t0_s5_reg;
                hb_w = t1_s5_reg + t2_s5_reg + t0_s5_reg;
                hc_w = t0_s5_reg;
            end
            svpwm_pkg::SX_AC: begin
                ha_w = t0_s5_reg;
                hb_w = t1_s5_reg + t2_s5_reg + t0_s5_reg;
                hc_w = t2_s5_reg + t0_s5_reg;
            end
            svpwm_pkg::SX_C: begin
                ha_w = t0_s5_reg;
                hb_w = t2_s5_reg + t0_s5_reg;
                hc_w = t1_s5_reg + t2_s5_reg + t0_s5_reg;
            end
            svpwm_pkg::SX_BC: begin
                ha_w = t2_s5_reg + t0_s5_reg;
                hb_w = t0_s5_reg;
                hc_w = t1_s5_reg + t2_s5_reg + t0_s5_reg;
            end
            svpwm_pkg::SX_B: begin
                ha_w = t1_s5_reg + t2_s5_reg + t0_s5_reg;
                hb_w = t0_s5_reg;
                hc_w = t2_s5_reg + t0_s5_reg;
            end
            default: begin
                ha_w = '0;
                hb_w = '0;
                hc_w = '0;
            end
        endcase
    end

    assign esh_a_w = ea_s5_reg >>> svpwm_pkg::SHIFT_U;
    assign esh_b_w = eb_s5_reg >>> svpwm_pkg::SHIFT_U;
    assign esh_c_w = ec_s5_reg >>> svpwm_pkg::SHIFT_U;

    always_comb begin
        if (mode_s5_reg == svpwm_pkg::MODE_SECTOR) begin
            duty_a_next   = svpwm_pkg::ONE_Q - ha_w;
            duty_b_next   = svpwm_pkg::ONE_Q - hb_w;
            duty_c_next   = svpwm_pkg::ONE_Q - hc_w;
            code_out_next = code_s5_reg;
        end else begin
            duty_a_next   = $signed(esh_a_w[svpwm_pkg::DUTY_W-1:0]) + svpwm_pkg::HALF_Q;
            duty_b_next   = $signed(esh_b_w[svpwm_pkg::DUTY_W-1:0]) + svpwm_pkg::HALF_Q;
            duty_c_next   = $signed(esh_c_w[svpwm_pkg::DUTY_W-1:0]) + svpwm_pkg::HALF_Q;
            code_out_next = svpwm_pkg::SX_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            duty_a_s6_reg <= duty_a_next;
            duty_b_s6_reg <= duty_b_next;
            duty_c_s6_reg <= duty_c_next;
            code_s6_reg   <= code_out_next;
            mode_s6_reg   <= mode_s5_reg;
        end
    end

    // ---------------- stage 7: clamp, scale by period ----------------
    function automatic logic [svpwm_pkg::CLAMP_W-1:0] clamp_duty(
        input logic signed [svpwm_pkg::DUTY_W-1:0] d
    );
        logic [svpwm_pkg::CLAMP_W-1:0] r;
        if (d < 0) begin
            r = '0;
        end else if (d > svpwm_pkg::ONE_Q) begin
            r = svpwm_pkg::ONE_CL;
        end else begin
            r = d[svpwm_pkg::CLAMP_W-1:0];
        end
        return r;
    endfunction

    logic [svpwm_pkg::CLAMP_W-1:0] cl_a_w;
    logic [svpwm_pkg::CLAMP_W-1:0] cl_b_w;
    logic [svpwm_pkg::CLAMP_W-1:0] cl_c_w;
    logic [svpwm_pkg::CPROD_W-1:0] cp_a_w;
    logic [svpwm_pkg::CPROD_W-1:0] cp_b_w;
    logic [svpwm_pkg::CPROD_W-1:0] cp_c_w;

    logic [svpwm_pkg::CMP_W-1:0]   cmp_a_reg;
    logic [svpwm_pkg::CMP_W-1:0]   cmp_b_reg;
    logic [svpwm_pkg::CMP_W-1:0]   cmp_c_reg;
    logic [svpwm_pkg::CODE_W-1:0]  sext_reg;
    logic                          mode_s7_reg;

    assign cl_a_w = clamp_duty(duty_a_s6_reg);
    assign cl_b_w = clamp_duty(duty_b_s6_reg);
    assign cl_c_w = clamp_duty(duty_c_s6_reg);
    assign cp_a_w = cl_a_w * period_reg;
    assign cp_b_w = cl_b_w * period_reg;
    assign cp_c_w = cl_c_w * period_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            cmp_a_reg   <= cp_a_w[svpwm_pkg::FRAC_BITS+svpwm_pkg::CMP_W-1:svpwm_pkg::FRAC_BITS];
            cmp_b_reg   <= cp_b_w[svpwm_pkg::FRAC_BITS+svpwm_pkg::CMP_W-1:svpwm_pkg::FRAC_BITS];
            cmp_c_reg   <= cp_c_w[svpwm_pkg::FRAC_BITS+svpwm_pkg::CMP_W-1:svpwm_pkg::FRAC_BITS];
            sext_reg    <= code_s6_reg;
            mode_s7_reg <= mode_s6_reg;
        end
    end

    assign m_tdata = {{svpwm_pkg::M_PAD_W{1'b0}}, sext_reg, cmp_c_reg, cmp_b_reg, cmp_a_reg};

    // ---------------- assertions ----------------
    logic                        mid_out_w;
    logic                        cmp_load_w;
    logic [svpwm_pkg::CMP_W-1:0] cmp_max_w;

    assign mid_out_w  = m_tvalid && (mode_s7_reg == svpwm_pkg::MODE_MIDPOINT);
    assign cmp_load_w = vld_reg[svpwm_pkg::NUM_STAGES-2] && stage_en[svpwm_pkg::NUM_STAGES-1];

    always_comb begin
        cmp_max_w = cmp_a_reg;
        if (cmp_b_reg > cmp_max_w) cmp_max_w = cmp_b_reg;
        if (cmp_c_reg > cmp_max_w) cmp_max_w = cmp_c_reg;
    end

    `SVPWM_ASSERT_ALWAYS(a_stall_only_full, s_tready || (&vld_reg), "stall with empty stage")
    `SVPWM_ASSERT_IMPLY(a_no_all_sextant, m_tvalid, sext_reg != svpwm_pkg::SX_ALL, "sextant 7 seen")
    `SVPWM_ASSERT_IMPLY(a_midpoint_code, mid_out_w, sext_reg == svpwm_pkg::SX_NONE, "midpoint sextant")
    `SVPWM_ASSERT_NEXT(a_cmp_in_period, cmp_load_w, cmp_max_w <= $past(period_reg), "compare > period")

endmodule
